/* rtl/atr_pkg.sv */
// Package for the AT response recognizer: state and status codes, character
// constants, line counter sizing and the structs between the FSM and the top level.
// No dependencies.
package atr_pkg;

  localparam int MAX_LINES = 16;
  localparam int CNT_W     = $clog2(MAX_LINES + 1);
  localparam int LINES_W   = 5;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;

  typedef enum logic [4:0] {
    S_START     = 5'd0,
    S_LF1       = 5'd1,
    S_HEAD      = 5'd2,
    S_O         = 5'd3,
    S_OK_CR     = 5'd4,
    S_OK_LF     = 5'd5,
    S_E         = 5'd6,
    S_ER        = 5'd7,
    S_ERR       = 5'd8,
    S_ERRO      = 5'd9,
    S_ERROR_CR  = 5'd10,
    S_ERROR_LF  = 5'd11,
    S_TEXT      = 5'd12,
    S_TEXT_LF   = 5'd13,
    S_AFTER     = 5'd14,
    S_BLANK_LF  = 5'd15,
    S_FINAL     = 5'd16
  } state_t;

  typedef enum logic [1:0] {
    STAT_BUSY  = 2'd0,
    STAT_DONE  = 2'd1,
    STAT_FAULT = 2'd2
  } status_t;

  typedef struct packed {
    logic       advance;
    logic [7:0] rx_byte;
    logic       special_mode;
  } step_in_t;

  typedef struct packed {
    status_t              status;
    logic [LINES_W-1:0]   lines_seen;
  } step_out_t;

endpackage

/* rtl/atr_fsm.sv */
// Recognizer state machine and line counter for the AT response recognizer.
// Produces the result for the byte on step_i and updates state when it advances.
// Depends on atr_pkg.
module atr_fsm (
  input  logic              clk,
  input  logic              rst_n,
  input  atr_pkg::step_in_t  step_i,
  output atr_pkg::step_out_t step_o
);

  atr_pkg::state_t           state_r, state_nxt;
  logic [atr_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_cur, cnt_inc, cnt_upd;
  logic [7:0]                c;
  logic                      special;
  logic                      printable;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atr_pkg::S_START;
      cnt_r   <= '0;
    end else if (step_i.advance) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    c         = step_i.rx_byte;
    special   = step_i.special_mode;
    printable = (c >= atr_pkg::PRINT_LO) && (c <= atr_pkg::PRINT_HI);
    // A response starting afresh counts from zero.
    cnt_cur   = (state_r == atr_pkg::S_START) ? '0 : cnt_r;
    cnt_inc   = (cnt_cur < atr_pkg::CNT_W'(atr_pkg::MAX_LINES)) ? cnt_cur + 1'b1 : cnt_cur;
    cnt_upd   = cnt_cur;
    state_nxt = atr_pkg::S_START;
    step_o.status     = atr_pkg::STAT_FAULT;
    step_o.lines_seen = '0;

    case (state_r)
      atr_pkg::S_START: begin
        if (c == atr_pkg::CH_CR) begin
          state_nxt = atr_pkg::S_LF1;
          step_o.status = atr_pkg::STAT_BUSY;
        end
      end
      atr_pkg::S_LF1: begin
        if (c == atr_pkg::CH_LF) begin
          state_nxt = atr_pkg::S_HEAD;
          step_o.status = atr_pkg::STAT_BUSY;
          cnt_upd = cnt_inc;
        end
      end
      atr_pkg::S_HEAD: begin
        step_o.status = atr_pkg::STAT_BUSY;
        if (c == atr_pkg::CH_O) state_nxt = atr_pkg::S_O;
        else if (c == atr_pkg::CH_E) state_nxt = atr_pkg::S_E;
        else if (c == atr_pkg::CH_PLUS || special) state_nxt = atr_pkg::S_TEXT;
        else step_o.status = atr_pkg::STAT_FAULT;
      end
      atr_pkg::S_O: begin
        step_o.status = atr_pkg::STAT_BUSY;
        if (c == atr_pkg::CH_K) state_nxt = atr_pkg::S_OK_CR;
        else if (special) state_nxt = atr_pkg::S_TEXT;
        else step_o.status = atr_pkg::STAT_FAULT;
      end
      atr_pkg::S_OK_CR: begin
        if (c == atr_pkg::CH_CR) begin
          state_nxt = atr_pkg::S_OK_LF;
          step_o.status = atr_pkg::STAT_BUSY;
        end
      end
      atr_pkg::S_OK_LF, atr_pkg::S_ERROR_LF: begin
        if (c == atr_pkg::CH_LF) begin
          step_o.status     = atr_pkg::STAT_DONE;
          step_o.lines_seen = atr_pkg::LINES_W'(cnt_cur);
        end
      end
      atr_pkg::S_E: begin
        step_o.status = atr_pkg::STAT_BUSY;
        if (c == atr_pkg::CH_R) state_nxt = atr_pkg::S_ER;
        else if (special) state_nxt = atr_pkg::S_TEXT;
        else step_o.status = atr_pkg::STAT_FAULT;
      end
      atr_pkg::S_ER: begin
        step_o.status = atr_pkg::STAT_BUSY;
        if (c == atr_pkg::CH_R) state_nxt = atr_pkg::S_ERR;
        else if (special) state_nxt = atr_pkg::S_TEXT;
        else step_o.status = atr_pkg::STAT_FAULT;
      end
      atr_pkg::S_ERR: begin
        step_o.status = atr_pkg::STAT_BUSY;
        if (c == atr_pkg::CH_O) state_nxt = atr_pkg::S_ERRO;
        else if (special) state_nxt = atr_pkg::S_TEXT;
        else step_o.status = atr_pkg::STAT_FAULT;
      end
      atr_pkg::S_ERRO: begin
        if (c == atr_pkg::CH_R) begin
          state_nxt = atr_pkg::S_ERROR_CR;
          step_o.status = atr_pkg::STAT_BUSY;
        end
      end
      atr_pkg::S_ERROR_CR: begin
        if (c == atr_pkg::CH_CR) begin
          state_nxt = atr_pkg::S_ERROR_LF;
          step_o.status = atr_pkg::STAT_BUSY;
        end
      end
      atr_pkg::S_TEXT: begin
        step_o.status = atr_pkg::STAT_BUSY;
        if (printable) state_nxt = atr_pkg::S_TEXT;
        else if (c == atr_pkg::CH_CR) state_nxt = atr_pkg::S_TEXT_LF;
        else step_o.status = atr_pkg::STAT_FAULT;
      end
      atr_pkg::S_TEXT_LF: begin
        if (c == atr_pkg::CH_LF) begin
          state_nxt = atr_pkg::S_AFTER;
          step_o.status = atr_pkg::STAT_BUSY;
          cnt_upd = cnt_inc;
        end
      end
      atr_pkg::S_AFTER: begin
        step_o.status = atr_pkg::STAT_BUSY;
        if (c == atr_pkg::CH_CR) state_nxt = atr_pkg::S_BLANK_LF;
        else if (c == atr_pkg::CH_PLUS) state_nxt = atr_pkg::S_TEXT;
        else step_o.status = atr_pkg::STAT_FAULT;
      end
      atr_pkg::S_BLANK_LF: begin
        if (c == atr_pkg::CH_LF) begin
          state_nxt = atr_pkg::S_FINAL;
          step_o.status = atr_pkg::STAT_BUSY;
          cnt_upd = cnt_inc;
        end
      end
      atr_pkg::S_FINAL: begin
        step_o.status = atr_pkg::STAT_BUSY;
        if (c == atr_pkg::CH_O) state_nxt = atr_pkg::S_O;
        else if (c == atr_pkg::CH_E) state_nxt = atr_pkg::S_E;
        else step_o.status = atr_pkg::STAT_FAULT;
      end
      default: begin
        // Unused codes fall back to the start state quietly.
        step_o.status = atr_pkg::STAT_BUSY;
      end
    endcase

    cnt_nxt = (state_nxt == atr_pkg::S_START) ? '0 : cnt_upd;
  end

  // Line count is only reported with a completed response.
  a_lines_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    step_o.lines_seen != '0 |-> step_o.status == atr_pkg::STAT_DONE)
    else $error("lines_seen nonzero without completion");

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= atr_pkg::CNT_W'(atr_pkg::MAX_LINES))
    else $error("line counter above saturation limit");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_i.advance && state_nxt == atr_pkg::S_START |=> cnt_r == '0)
    else $error("line counter not cleared on return to start");

  a_fault_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    step_i.advance && step_o.status == atr_pkg::STAT_FAULT |=> state_r == atr_pkg::S_START)
    else $error("malformed byte did not return to start");

endmodule

/* rtl/at_response_recognizer.sv */
// Top level of the AT response recognizer: input register, result register
// and the handshakes around them. Depends on atr_pkg and atr_fsm.
//
// Usage: one received modem byte (in_rx_byte) and the mode bit (in_special_mode)
// are transferred on the input channel when in_valid is high and in_stall is low.
// Every byte produces exactly one result transfer on the output channel:
// out_status (0 in progress, 1 response complete, 2 malformed) and
// out_lines_seen, the number of line breaks before the final OK or ERROR
// line, saturating at the package limit, nonzero only with a completed response.
// The recognizer state machine evaluates the byte while it sits in the input
// register, and the output register captures the result when the byte moves on.
// Throughput is one byte per cycle while the receiver does not stall; the state
// update of the recognizer sets that rate.
// When the receiver stalls, the result register holds its value, the input
// register holds its byte, and in_stall rises only when both are occupied, so
// one further byte can be transferred while a finished result waits.
// Reset (rst_n low, synchronous) empties both registers and returns the
// recognizer to the start state with the line counter at zero.
module at_response_recognizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_special_mode,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [4:0] out_lines_seen
);

  // Input register stage.
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_mode_r;

  // Result register stage.
  logic                          out_valid_r, out_valid_nxt;
  atr_pkg::status_t              out_status_r;
  logic [atr_pkg::LINES_W-1:0]   out_lines_r;

  logic                in_take;
  logic                s1_adv;
  atr_pkg::step_in_t   step_in;
  atr_pkg::step_out_t  step_out;

  // The byte in the input register moves on whenever the result register is
  // empty or its result is being transferred out in this cycle.
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    step_in.advance      = s1_adv;
    step_in.rx_byte      = s1_byte_r;
    step_in.special_mode = s1_mode_r;
    s1_valid_nxt  = in_take || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && out_stall);
  end

  atr_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step_in),
    .step_o (step_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers load only on a transfer into their stage.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
      s1_mode_r <= in_special_mode;
    end
    if (s1_adv) begin
      out_status_r <= step_out.status;
      out_lines_r  <= step_out.lines_seen;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_lines_seen = out_lines_r;

  // Backpressure on the input only arises with a byte waiting in stage one.
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked byte");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced byte produced no result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_status != 2'd3)
    else $error("undefined status code on output");

endmodule
